/* rtl/core/wildcard_glob_matcher_top_macros.svh */
// Assertion helpers shared by the matcher RTL.
// Each macro expands to one labeled concurrent assertion on aclk that is
// switched off while aresetn is low.
`ifndef WILDCARD_GLOB_MATCHER_TOP_MACROS_SVH
`define WILDCARD_GLOB_MATCHER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GWM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GWM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/gwm_pkg.sv */
package gwm_pkg;

    // Pattern store depth and derived widths.
    localparam int PAT_MAX   = 64;
    localparam int ROW_W     = PAT_MAX + 1;
    localparam int SCAN_LVLS = $clog2(ROW_W);
    localparam int LEN_W     = 7;
    localparam int IDX_W     = 6;
    localparam int CHAR_W    = 8;

    // Wildcard codes.
    localparam logic [CHAR_W-1:0] STAR_CODE = 8'd42;
    localparam logic [CHAR_W-1:0] ANY_CODE  = 8'd63;

    // Request codes on s_req_type.
    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_START = 2'd1,
        REQ_TEXT  = 2'd2
    } req_type_t;

    typedef logic [CHAR_W-1:0]              char_t;
    typedef logic [LEN_W-1:0]               len_t;
    typedef logic [ROW_W-1:0]               row_t;
    typedef logic [PAT_MAX-1:0][CHAR_W-1:0] pat_chars_t;

    // Controls for one row update.
    typedef struct packed {
        logic  start;
        char_t text_char;
        len_t  eff_len;
    } row_ctl_t;

    // Row positions 0..n are live; everything above is forced to zero.
    function automatic row_t len_mask(len_t n);
        row_t m;
        for (int j = 0; j < ROW_W; j++) begin
            m[j] = (j <= int'(n));
        end
        return m;
    endfunction

    // Log-depth prefix scan of next[j] = g[j] | (p[j] & next[j-1]).
    function automatic row_t prefix_scan(row_t g, row_t p);
        row_t gg;
        row_t pp;
        row_t gn;
        row_t pn;
        gg = g;
        pp = p;
        for (int l = 0; l < SCAN_LVLS; l++) begin
            for (int i = 0; i < ROW_W; i++) begin
                if (i >= (1 << l)) begin
                    gn[i] = gg[i] | (pp[i] & gg[i - (1 << l)]);
                    pn[i] = pp[i] & pp[i - (1 << l)];
                end else begin
                    gn[i] = gg[i];
                    pn[i] = pp[i];
                end
            end
            gg = gn;
            pp = pn;
        end
        return gg;
    endfunction

endpackage

/* rtl/core/gwm_row_update.sv */
module gwm_row_update (
    input  gwm_pkg::row_t       row_i,
    input  gwm_pkg::pat_chars_t chars_i,
    input  gwm_pkg::row_ctl_t   ctl_i,
    output gwm_pkg::row_t       row_o
);

    gwm_pkg::row_t gen;
    gwm_pkg::row_t prop;
    gwm_pkg::row_t scanned;

    // Per-position generate and propagate terms. A star keeps its old-row bit
    // and passes the bit from its left neighbor in the new row; any other
    // position takes a diagonal step from the old row when the text byte fits.
    always_comb begin
        gen[0]  = ctl_i.start;
        prop[0] = 1'b0;
        for (int j = 1; j < gwm_pkg::ROW_W; j++) begin
            prop[j] = (chars_i[j-1] == gwm_pkg::STAR_CODE);
            if (ctl_i.start) begin
                gen[j] = 1'b0;
            end else if (prop[j]) begin
                gen[j] = row_i[j];
            end else begin
                gen[j] = row_i[j-1] &
                         ((chars_i[j-1] == ctl_i.text_char) |
                          (chars_i[j-1] == gwm_pkg::ANY_CODE));
            end
        end
    end

    // Resolve the star chain and clear positions beyond the pattern length.
    assign scanned = gwm_pkg::prefix_scan(gen, prop);
    assign row_o   = scanned & gwm_pkg::len_mask(ctl_i.eff_len);

endmodule

/* rtl/core/wildcard_glob_matcher_top.sv */
// Channel  Direction  Ports                                             Handshake
// s_       in         s_req_type s_pattern_index s_pattern_char
//                     s_text_char                                       s_valid/s_ready
// m_       out        m_matched                                         m_valid/m_ready
// cfg_     in         cfg_wr_data (pattern_length)                      cfg_wr_en
//
// One transfer per cycle is sustained while results are taken: an item sits
// in the input register, then the row update (parallel compares plus a
// log-depth star scan) writes the match row and the result register, which
// drives m_valid.
// Reset clears the match row to bit zero only, the length to zero and both
// valid flags; the pattern store is not cleared.
// While a result waits, a load in the input register still completes; a start
// or text byte waits there and stalls the input until the result moves.
`include "wildcard_glob_matcher_top_macros.svh"

module wildcard_glob_matcher_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Configuration write.
    input  logic                        cfg_wr_en,
    input  logic [gwm_pkg::LEN_W-1:0]   cfg_wr_data,
    // Request channel.
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_req_type,
    input  logic [gwm_pkg::IDX_W-1:0]   s_pattern_index,
    input  logic [gwm_pkg::CHAR_W-1:0]  s_pattern_char,
    input  logic [gwm_pkg::CHAR_W-1:0]  s_text_char,
    // Result channel.
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_matched
);

    // Input stage.
    logic                       s1_valid_reg;
    logic [1:0]                 s1_req_reg;
    logic [gwm_pkg::IDX_W-1:0]  s1_idx_reg;
    gwm_pkg::char_t             s1_pchar_reg;
    gwm_pkg::char_t             s1_tchar_reg;

    // Block state.
    gwm_pkg::pat_chars_t        chars_reg;
    gwm_pkg::row_t              row_reg;
    gwm_pkg::row_t              row_next;
    gwm_pkg::len_t              eff_len_reg;
    gwm_pkg::len_t              eff_len_next;
    gwm_pkg::row_ctl_t          upd_ctl;

    // Result stage.
    logic                       m_valid_reg;
    logic                       m_matched_reg;

    logic                       has_result;
    logic                       out_free;
    logic                       s1_fire;
    logic                       do_update;
    logic                       do_load;

    // Handshake between the two stages.
    assign has_result = (s1_req_reg == gwm_pkg::REQ_START) ||
                        (s1_req_reg == gwm_pkg::REQ_TEXT);
    assign out_free   = !m_valid_reg || m_ready;
    assign s1_fire    = s1_valid_reg && (!has_result || out_free);
    assign s_ready    = !s1_valid_reg || s1_fire;
    assign do_update  = s1_fire && has_result;
    assign do_load    = s1_fire && (s1_req_reg == gwm_pkg::REQ_LOAD) &&
                        (int'(s1_idx_reg) < gwm_pkg::PAT_MAX);

    // Lengths above the store depth saturate.
    assign eff_len_next = (int'(cfg_wr_data) > gwm_pkg::PAT_MAX) ?
                          gwm_pkg::LEN_W'(gwm_pkg::PAT_MAX) : cfg_wr_data;

    // Row update logic.
    always_comb begin
        upd_ctl.start     = (s1_req_reg == gwm_pkg::REQ_START);
        upd_ctl.text_char = s1_tchar_reg;
        upd_ctl.eff_len   = eff_len_reg;
    end

    gwm_row_update u_row_update (
        .row_i   (row_reg),
        .chars_i (chars_reg),
        .ctl_i   (upd_ctl),
        .row_o   (row_next)
    );

    // Input register: capture a request on each input transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            s1_req_reg   <= s_req_type;
            s1_idx_reg   <= s_pattern_index;
            s1_pchar_reg <= s_pattern_char;
            s1_tchar_reg <= s_text_char;
        end
    end

    // Pattern store, written by load requests.
    always_ff @(posedge aclk) begin
        if (do_load) begin
            chars_reg[s1_idx_reg] <= s1_pchar_reg;
        end
    end

    // Match row and configured length.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg     <= gwm_pkg::ROW_W'(1);
            eff_len_reg <= '0;
        end else begin
            if (do_update) begin
                row_reg <= row_next;
            end
            if (cfg_wr_en) begin
                eff_len_reg <= eff_len_next;
            end
        end
    end

    // Result register: holds its value until the output transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (do_update) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (do_update) begin
            m_matched_reg <= row_next[eff_len_reg];
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_matched = m_matched_reg;

    // A start leaves the empty-prefix bit set.
    `GWM_ASSERT_NEXT(a_start_sets_bit0, do_update && upd_ctl.start, row_reg[0], "start did not set row bit 0")
    // A text byte always clears the empty-prefix bit.
    `GWM_ASSERT_NEXT(a_text_clears_bit0, do_update && !upd_ctl.start, !row_reg[0], "text byte left row bit 0 set")
    // No live bit survives above the length used for the update.
    `GWM_ASSERT_NEXT(a_row_masked, do_update, (row_reg & ~$past(gwm_pkg::len_mask(eff_len_reg))) == '0, "row bit set above pattern length")
    // A finished result never gets overwritten while still pending.
    `GWM_ASSERT_SAME(a_no_overwrite, do_update, !m_valid_reg || m_ready, "result register overwritten before transfer")

endmodule
